@@ rtl/blend_space_1d_range_select_assert.svh @@
// assertion macros shared by the range select rtl
`ifndef BLEND_SPACE_1D_RANGE_SELECT_ASSERT_SVH
`define BLEND_SPACE_1D_RANGE_SELECT_ASSERT_SVH

// check that cond implies next-cycle result
`define BSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// check a same-cycle implication
`define BSR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/bsr_pkg.sv @@
// shared types and constants for the range select block
`timescale 1ns / 1ps
`default_nettype none
package bsr_pkg;
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam int VAL_W  = 16;
    localparam int SRC_W  = 4;
    localparam int FRAC_W = 17;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // command broadcast along the row of cells
    typedef struct packed {
        logic               shift_en;   // insert step of a load
        logic signed [15:0] value;
    } bsr_cmd_t;
endpackage
`default_nettype wire

@@ rtl/bsr_cell.sv @@
// one breakpoint slot: holds a value and source id, shifts up on insert
`timescale 1ns / 1ps
`default_nettype none
module bsr_cell #(
    parameter int IDW = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bsr_pkg::bsr_cmd_t  cmd,
    input  wire logic               take_new,   // this slot receives the new value
    input  wire logic [IDW-1:0]     new_id,
    input  wire logic signed [15:0] left_value,
    input  wire logic [IDW-1:0]     left_id,
    input  wire logic               left_gt,    // left neighbor value greater than new
    output logic signed [15:0]      value,
    output logic [IDW-1:0]          id,
    output logic                    gt
);
    logic signed [15:0] value_reg;
    logic [IDW-1:0]     id_reg;

    assign value = value_reg;
    assign id    = id_reg;
    // this slot moves up when it holds a value above the new one
    assign gt    = value_reg > cmd.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            id_reg    <= '0;
        end
        else if (cmd.shift_en)
        begin
            // only slots in [pos, count] change; caller gates via take_new/left_gt
            if (left_gt)
            begin
                value_reg <= left_value;
                id_reg    <= left_id;
            end
            else if (take_new)
            begin
                value_reg <= cmd.value;
                id_reg    <= new_id;
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/bsr_divider.sv @@
// restoring divider for the blend fraction, one quotient bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module bsr_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [16:0] num,   // v - lo
    input  wire logic [16:0] den,   // hi - lo, nonzero
    output logic             done,
    output logic [16:0]      quot
);
    logic [33:0] rem_reg, rem_next;
    logic [32:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] trial;

    assign trial = {rem_reg[32:0], q_reg[32]} - {17'd0, den};

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            q_next    = {num, 16'd0};
            cnt_next  = 6'd33;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[33]) begin
                rem_next = trial;
                q_next   = {q_reg[31:0], 1'b1};
            end else begin
                rem_next = {rem_reg[32:0], q_reg[32]};
                q_next   = {q_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = busy_reg && cnt_reg == 6'd1;
    // quotient <= 65536 since v <= hi; clamp anyway
    assign quot = (q_next[32:17] != '0 || q_next[16:0] > 17'h10000) ?
                  17'h10000 : q_next[16:0];
endmodule
`default_nettype wire

@@ rtl/blend_space_1d_range_select.sv @@
// Sorted breakpoint store with interval lookup. Breakpoints live in a row of
// MAX_SOURCES cells; a load inserts by shifting greater entries up one cell, so
// it stalls the input for one cycle; a clear, a dropped load or an unused op
// stalls nothing. A query clamps the value, then scans the cells one pair per
// cycle for the first pair that holds it, and when at least two breakpoints are
// held and that pair spans a nonempty range it runs a 33-step restoring divider:
// a query keeps the input stalled through its scan and any division, and its
// result goes to the output register when either ends. The result sits in
// that register, so the next item is taken while it waits; a later query
// only finishes its scan once that register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "blend_space_1d_range_select_assert.svh"
module blend_space_1d_range_select #(
    parameter int MAX_SOURCES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        op,
    input  wire logic signed [15:0] sample_value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [3:0]             first_source,
    output logic [3:0]             second_source,
    output logic [16:0]            blend_fraction,
    output logic                   single_source,
    output logic                   result_valid,
    output logic                   overflow_flag
);
    localparam int IDW = $clog2(MAX_SOURCES);
    localparam int CW  = $clog2(MAX_SOURCES + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_SOURCES);

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_SCAN, S_DIV} state_t;
    state_t state_reg;

    logic signed [15:0] v_reg;
    logic [CW-1:0]      count_reg;
    logic               drop_reg;
    logic [IDW-1:0]     idx_reg;
    logic               ov_reg;

    bsr_pkg::bsr_cmd_t  cmd;
    logic signed [15:0] cval [MAX_SOURCES];
    logic [IDW-1:0]     cid  [MAX_SOURCES];
    logic               cgt  [MAX_SOURCES];

    assign cmd = '{shift_en: state_reg == S_LOAD, value: v_reg};

    for (genvar g = 0; g < MAX_SOURCES; g++)
    begin : g_cell
        logic signed [15:0] lv;
        logic [IDW-1:0]     lid;
        logic               lgt;
        logic               take;
        if (g == 0)
        begin : g_first
            assign lv  = '0;
            assign lid = '0;
            assign lgt = 1'b0;
        end
        else
        begin : g_rest
            assign lv  = cval[g-1];
            assign lid = cid[g-1];
            assign lgt = cgt[g-1] && (CW'(g) <= count_reg);
        end
        // new value lands in the lowest held slot above it, or at the free end
        assign take = (CW'(g) == count_reg) || (cgt[g] && (CW'(g) < count_reg));
        bsr_cell #(.IDW(IDW)) u_cell (
            .clk(clk), .rst_n(rst_n), .cmd(cmd), .take_new(take),
            .new_id(count_reg[IDW-1:0]), .left_value(lv), .left_id(lid),
            .left_gt(lgt), .value(cval[g]), .id(cid[g]), .gt(cgt[g]));
    end

    // scan pair at idx_reg
    logic signed [15:0] lo, hi, top, vc;
    logic               hold, last_pair;
    assign lo  = cval[idx_reg];
    assign hi  = cval[IDW'(idx_reg + 1'b1)];
    assign top = cval[IDW'(count_reg - 1'b1)];
    assign vc  = (v_reg < cval[0]) ? cval[0] : ((v_reg > top) ? top : v_reg);
    assign hold = lo <= vc && vc <= hi;
    assign last_pair = CW'(idx_reg) + CW'(2) >= count_reg;

    logic        out_busy, scan_end, result_load;
    logic        div_start, div_done;
    logic [16:0] div_q;
    logic [16:0] dnum, dden;
    assign dnum = 17'(vc - lo);
    assign dden = 17'(hi - lo);

    // a scan only ends once the output register can take its result
    assign out_busy    = out_valid && out_stall;
    assign scan_end    = state_reg == S_SCAN && !out_busy &&
                         (count_reg < CW'(2) || hold || last_pair);
    assign div_start   = scan_end && count_reg >= CW'(2) && hi > lo && vc >= lo;
    assign result_load = (scan_end && !div_start) || (state_reg == S_DIV && div_done);

    bsr_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(dnum), .den(dden),
        .done(div_done), .quot(div_q));

    assign in_stall = state_reg != S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            drop_reg       <= 1'b0;
            out_valid      <= 1'b0;
            idx_reg        <= '0;
            v_reg          <= '0;
            ov_reg         <= 1'b0;
            first_source   <= '0;
            second_source  <= '0;
            blend_fraction <= '0;
            single_source  <= 1'b0;
            result_valid   <= 1'b0;
            overflow_flag  <= 1'b0;
        end
        else
        begin
            if (result_load)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (!in_stall && in_valid)
                    begin
                        v_reg   <= sample_value;
                        idx_reg <= '0;
                        ov_reg  <= drop_reg;
                        priority if (op == bsr_pkg::OP_CLEAR)
                        begin
                            count_reg <= '0;
                            drop_reg  <= 1'b0;
                        end
                        else if (op == bsr_pkg::OP_LOAD)
                        begin
                            if (count_reg >= FULL)
                                drop_reg <= 1'b1;
                            else
                                state_reg <= S_LOAD;
                        end
                        else if (op == bsr_pkg::OP_QUERY)
                            state_reg <= S_SCAN;
                        else
                            state_reg <= S_IDLE;
                    end
                end
                S_LOAD:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    priority if (count_reg >= CW'(2) && !hold && !last_pair)
                        idx_reg <= idx_reg + 1'b1;
                    else if (scan_end)
                    begin
                        priority if (count_reg < CW'(2))
                        begin
                            first_source   <= '0;
                            second_source  <= '0;
                            blend_fraction <= '0;
                            single_source  <= 1'b0;
                            result_valid   <= 1'b0;
                            overflow_flag  <= ov_reg;
                            state_reg      <= S_IDLE;
                        end
                        else if (div_start)
                            state_reg <= S_DIV;
                        else
                        begin
                            first_source   <= 4'(cid[idx_reg]);
                            second_source  <= 4'(cid[idx_reg]);
                            blend_fraction <= '0;
                            single_source  <= 1'b1;
                            result_valid   <= 1'b1;
                            overflow_flag  <= ov_reg;
                            state_reg      <= S_IDLE;
                        end
                    end
                    else
                        state_reg <= S_SCAN;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        blend_fraction <= div_q;
                        single_source  <= div_q == 17'd0 || div_q == bsr_pkg::FRAC_ONE;
                        if (div_q == bsr_pkg::FRAC_ONE)
                        begin
                            first_source  <= 4'(cid[IDW'(idx_reg + 1'b1)]);
                            second_source <= 4'(cid[IDW'(idx_reg + 1'b1)]);
                        end
                        else if (div_q == 17'd0)
                        begin
                            first_source  <= 4'(cid[idx_reg]);
                            second_source <= 4'(cid[idx_reg]);
                        end
                        else
                        begin
                            first_source  <= 4'(cid[idx_reg]);
                            second_source <= 4'(cid[IDW'(idx_reg + 1'b1)]);
                        end
                        result_valid  <= 1'b1;
                        overflow_flag <= ov_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `BSR_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_reg <= FULL)
    `BSR_ASSERT_IMPL(a_single_frac, clk, rst_n, out_valid && single_source,
        blend_fraction == 17'd0 || blend_fraction == bsr_pkg::FRAC_ONE)
    `BSR_ASSERT_IMPL(a_invalid_zero, clk, rst_n, out_valid && !result_valid,
        blend_fraction == 17'd0 && !single_source)
    `BSR_ASSERT_NEXT(a_load_grows, clk, rst_n, state_reg == S_LOAD,
        count_reg == $past(count_reg) + 1'b1)
    `BSR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(blend_fraction) && $stable(first_source))
endmodule
`default_nettype wire
